[rtl/core/fbfl_pkg.sv]
// fbfl_pkg: shared constants, codes and request/response types of the block pool allocator
package fbfl_pkg;

    // pool geometry
    localparam int MAX_BLOCKS   = 1024;
    localparam int LINK_AW      = 10;
    localparam int LINK_W       = 11;
    localparam int OFFSET_BITS  = 20;
    localparam int CFG_W        = 20;
    localparam int RSIZE_W      = 21;
    localparam int DIV_CNT_W    = 5;

    // alignment is a power of two, so rounding up is add and mask
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int DATA_START   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

    // configuration register indexes
    localparam logic [0:0] CFG_BLOCK_SIZE    = 1'b0;
    localparam logic [0:0] CFG_BUFFER_LENGTH = 1'b1;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_INIT  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_TOO_SMALL = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } t_status;

    // input request
    typedef struct packed {
        t_func       func;
        logic [9:0]  block_index;
    } t_req;

    // output response
    typedef struct packed {
        logic [10:0] result_index;
        logic [19:0] block_offset;
        t_status     status;
        logic        initialized;
    } t_rsp;

endpackage

[rtl/core/fbfl_div.sv]
// fbfl_div: restoring divider, one quotient bit per cycle, for the block count at init
module fbfl_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [fbfl_pkg::OFFSET_BITS-1:0]     i_dividend,
    input  logic [fbfl_pkg::RSIZE_W-1:0]         i_divisor,
    output logic                                 o_done,
    output logic [fbfl_pkg::OFFSET_BITS-1:0]     o_quotient
);

    localparam logic [fbfl_pkg::DIV_CNT_W-1:0] LAST_STEP =
        fbfl_pkg::DIV_CNT_W'(fbfl_pkg::OFFSET_BITS - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [fbfl_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [fbfl_pkg::RSIZE_W-1:0]        r_rem;
    logic [fbfl_pkg::RSIZE_W-1:0]        r_dvs;
    logic [fbfl_pkg::OFFSET_BITS-1:0]    r_quo;

    logic [fbfl_pkg::RSIZE_W-1:0]        trial;
    logic                                fits;
    logic [fbfl_pkg::RSIZE_W-1:0]        n_rem;

    // one shift and trial subtract
    always_comb begin
        trial = {r_rem[fbfl_pkg::RSIZE_W-2:0], r_quo[fbfl_pkg::OFFSET_BITS-1]};
        fits  = (trial >= r_dvs);
        n_rem = fits ? (trial - r_dvs) : trial;
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[fbfl_pkg::OFFSET_BITS-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/core/fixed_block_free_list_allocator_unit.sv]
// fixed_block_free_list_allocator_unit: block pool with its free list held in a link memory
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_in_req  (func, index)
//  out     | out       | o_out_valid / i_out_ready  | o_out_rsp (index, offset,
//          |           |                            |  status, initialized)
//  cfg     | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// free, no-op and alloc from an empty pool answer from the idle state; alloc
// waits a state for the registered read of the link memory at the list head.
// init: the divider start, 20 divider steps, taking the quotient, one multiply,
// then one link memory write per block; when the buffer is too short, init
// ends once the quotient is taken.
// one request at a time; a finished response waits in the output register, and
// a further one is held internally while the output stays stalled.
// synchronous active-low reset; the link memory has no reset and needs no clearing pass.
module fixed_block_free_list_allocator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fbfl_pkg::t_req                    i_in_req,
    // response channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fbfl_pkg::t_rsp                    o_out_rsp,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [fbfl_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam logic [fbfl_pkg::RSIZE_W-1:0] ALIGN_MASK =
        fbfl_pkg::RSIZE_W'(fbfl_pkg::ALIGN_BYTES - 1);
    localparam logic [fbfl_pkg::OFFSET_BITS-1:0] START =
        fbfl_pkg::OFFSET_BITS'(fbfl_pkg::DATA_START);
    localparam logic [fbfl_pkg::OFFSET_BITS-1:0] MAX_QUO =
        fbfl_pkg::OFFSET_BITS'(fbfl_pkg::MAX_BLOCKS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ALLOC = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_LINK  = 6'b010000,
        ST_RESP  = 6'b100000
    } t_state;

    t_state                               r_state, n_state;
    logic [fbfl_pkg::CFG_W-1:0]           r_block_size;
    logic [fbfl_pkg::CFG_W-1:0]           r_buf_len;
    logic [fbfl_pkg::LINK_W-1:0]          r_head, n_head;
    logic [fbfl_pkg::LINK_W-1:0]          r_total, n_total;
    logic [fbfl_pkg::OFFSET_BITS-1:0]     r_first, n_first;
    logic                                 r_ready, n_ready;
    logic [fbfl_pkg::RSIZE_W-1:0]         r_rsize, n_rsize;
    logic [fbfl_pkg::OFFSET_BITS-1:0]     r_aprod, n_aprod;
    logic [fbfl_pkg::LINK_W-1:0]          r_n, n_n;
    logic [fbfl_pkg::OFFSET_BITS-1:0]     r_mul, n_mul;
    logic [fbfl_pkg::LINK_AW-1:0]         r_cnt, n_cnt;
    fbfl_pkg::t_rsp                       r_res, n_res;
    logic                                 r_out_valid, n_out_valid;
    fbfl_pkg::t_rsp                       r_out, n_out;

    // link memory
    logic [fbfl_pkg::LINK_W-1:0]          mem_link [fbfl_pkg::MAX_BLOCKS];
    logic [fbfl_pkg::LINK_W-1:0]          r_rd_data;
    logic                                 rd_en;
    logic                                 w_en;
    logic [fbfl_pkg::LINK_AW-1:0]         w_addr;
    logic [fbfl_pkg::LINK_W-1:0]          w_data;

    logic                                 slot_free;
    logic [fbfl_pkg::CFG_W-1:0]           bs_nz;
    logic [fbfl_pkg::RSIZE_W-1:0]         rs_calc;
    logic [fbfl_pkg::OFFSET_BITS-1:0]     dividend;
    logic                                 div_start;
    logic                                 div_done;
    logic [fbfl_pkg::OFFSET_BITS-1:0]     div_quo;
    logic [30:0]                          aprod_full;
    logic [31:0]                          mul_full;
    logic [fbfl_pkg::LINK_W-1:0]          cnt_inc;
    logic                                 fin_valid;
    fbfl_pkg::t_rsp                       fin_rsp;

    // block size rounding and carve length
    always_comb begin
        bs_nz    = (r_block_size == '0) ? fbfl_pkg::CFG_W'(1) : r_block_size;
        rs_calc  = ({1'b0, bs_nz} + ALIGN_MASK) & ~ALIGN_MASK;
        dividend = (r_buf_len >= START) ? (r_buf_len - START) : '0;
    end

    // products: allocated block offset and carved span
    assign aprod_full = r_head[fbfl_pkg::LINK_AW-1:0] * r_rsize;
    assign mul_full   = r_n * r_rsize;
    assign cnt_inc    = {1'b0, r_cnt} + 1'b1;

    assign slot_free  = !r_out_valid || i_out_ready;

    // block count divider
    fbfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (rs_calc),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_total     = r_total;
        n_first     = r_first;
        n_ready     = r_ready;
        n_rsize     = r_rsize;
        n_aprod     = r_aprod;
        n_n         = r_n;
        n_mul       = r_mul;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        w_en        = 1'b0;
        w_addr      = r_cnt;
        w_data      = fbfl_pkg::NULL_LINK;
        div_start   = 1'b0;
        fin_valid   = 1'b0;
        fin_rsp     = '{result_index: '0, block_offset: '0,
                        status: fbfl_pkg::STAT_OK, initialized: r_ready};

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_req.func)
                        fbfl_pkg::FUNC_ALLOC: begin
                            if (r_head == fbfl_pkg::NULL_LINK) begin
                                fin_valid      = 1'b1;
                                fin_rsp.status = fbfl_pkg::STAT_NO_FREE;
                            end else begin
                                rd_en   = 1'b1;
                                n_aprod = aprod_full[fbfl_pkg::OFFSET_BITS-1:0];
                                n_state = ST_ALLOC;
                            end
                        end
                        fbfl_pkg::FUNC_FREE: begin
                            fin_valid = 1'b1;
                            if ({1'b0, i_in_req.block_index} >= r_total) begin
                                fin_rsp.status = fbfl_pkg::STAT_BAD_INDEX;
                            end else begin
                                w_en   = 1'b1;
                                w_addr = i_in_req.block_index;
                                w_data = r_head;
                                n_head = {1'b0, i_in_req.block_index};
                            end
                        end
                        fbfl_pkg::FUNC_INIT: begin
                            n_rsize   = rs_calc;
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                        default: begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end
            // link data of the popped block is back
            ST_ALLOC: begin
                n_head               = r_rd_data;
                fin_valid            = 1'b1;
                fin_rsp.result_index = r_head;
                fin_rsp.block_offset = r_first + r_aprod;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_n = (div_quo > MAX_QUO) ? fbfl_pkg::LINK_W'(fbfl_pkg::MAX_BLOCKS)
                                              : div_quo[fbfl_pkg::LINK_W-1:0];
                    if (div_quo == '0) begin
                        n_total             = '0;
                        n_head              = fbfl_pkg::NULL_LINK;
                        n_first             = '0;
                        n_ready             = 1'b0;
                        fin_valid           = 1'b1;
                        fin_rsp.status      = fbfl_pkg::STAT_TOO_SMALL;
                        fin_rsp.initialized = 1'b0;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_mul   = mul_full[fbfl_pkg::OFFSET_BITS-1:0];
                n_cnt   = '0;
                n_state = ST_LINK;
            end
            // chain blocks lowest first, one write a cycle
            ST_LINK: begin
                w_en   = 1'b1;
                w_addr = r_cnt;
                w_data = (cnt_inc < r_n) ? cnt_inc : fbfl_pkg::NULL_LINK;
                n_cnt  = r_cnt + 1'b1;
                if (cnt_inc == r_n) begin
                    n_total              = r_n;
                    n_first              = r_buf_len - r_mul;
                    n_head               = '0;
                    n_ready              = 1'b1;
                    fin_valid            = 1'b1;
                    fin_rsp.result_index = r_n;
                    fin_rsp.initialized  = 1'b1;
                end
            end
            ST_RESP: begin
                fin_valid = 1'b1;
                fin_rsp   = r_res;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output register and holding of a stalled response
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (fin_valid) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out       = fin_rsp;
                n_state     = ST_IDLE;
            end else begin
                n_res   = fin_rsp;
                n_state = ST_RESP;
            end
        end
    end

    // control and pool state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= fbfl_pkg::NULL_LINK;
            r_total     <= '0;
            r_first     <= '0;
            r_ready     <= 1'b0;
            r_rsize     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_total     <= n_total;
            r_first     <= n_first;
            r_ready     <= n_ready;
            r_rsize     <= n_rsize;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_aprod <= n_aprod;
        r_n     <= n_n;
        r_mul   <= n_mul;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= fbfl_pkg::CFG_W'(8);
            r_buf_len    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fbfl_pkg::CFG_BLOCK_SIZE) begin
                r_block_size <= i_cfg_data;
            end
            if (i_cfg_idx == fbfl_pkg::CFG_BUFFER_LENGTH) begin
                r_buf_len <= i_cfg_data;
            end
        end
    end

    // link memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_link[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= mem_link[r_head[fbfl_pkg::LINK_AW-1:0]];
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef SYNTHESIS
    // a ready pool always holds blocks
    a_ready_has_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_total != '0))
        else $error("pool ready with no blocks");

    // the list head is null or a block of the pool
    a_head_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == fbfl_pkg::NULL_LINK) || (r_head < r_total))
        else $error("free list head outside the pool");

    // the divider only finishes while init waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside init");

    // a popped head is only taken from a non-empty list
    a_alloc_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |-> (r_head != fbfl_pkg::NULL_LINK))
        else $error("alloc read at null head");
`endif

endmodule
